/* sv/irpd_pkg.sv */
// ----------------------------------------------------------------------------
// irpd_pkg - shared types and constants
// Register indexes, reset values, edge kind codes and the structs that pass
// between the blocks of the IR pulse interval decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

	localparam int INTERVAL_W = 32;
	localparam int CODE_W     = 32;
	localparam int KIND_W     = 2;
	localparam int COUNT_W    = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

	// edge kind codes
	localparam logic [KIND_W-1:0] EDGE_FALL = 2'd0;
	localparam logic [KIND_W-1:0] EDGE_RISE = 2'd1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MAX    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN_A   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN_B   = 3'd4;

	// register reset values
	localparam logic [INTERVAL_W-1:0] RST_BIT_THRESHOLD = 32'd14722;
	localparam logic [INTERVAL_W-1:0] RST_HEADER_MIN    = 32'd60433;
	localparam logic [INTERVAL_W-1:0] RST_HEADER_MAX    = 32'd900000;
	localparam logic [COUNT_W-1:0]    RST_FRAME_LEN_A   = 6'd33;
	localparam logic [COUNT_W-1:0]    RST_FRAME_LEN_B   = 6'd35;

	typedef struct packed {
		logic [INTERVAL_W-1:0] bit_threshold;
		logic [INTERVAL_W-1:0] header_min;
		logic [INTERVAL_W-1:0] header_max;
		logic [COUNT_W-1:0]    frame_len_a;
		logic [COUNT_W-1:0]    frame_len_b;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		logic       push;
		logic       pop;
	} queue_stat_t;

endpackage

/* sv/irpd_if.sv */
// ----------------------------------------------------------------------------
// irpd_if - stream channels of the decoder
// Edge event channel and decoded code channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface irpd_edge_if;
	logic        valid;
	logic        ready;
	logic [1:0]  edge_kind;
	logic [31:0] interval;

	modport source(output valid, output edge_kind, output interval, input ready);
	modport sink(input valid, input edge_kind, input interval, output ready);
endinterface

interface irpd_code_if;
	logic        valid;
	logic        ready;
	logic [31:0] code;

	modport source(output valid, output code, input ready);
	modport sink(input valid, input code, output ready);
endinterface

/* sv/ir_pulse_interval_decoder.sv */
// ----------------------------------------------------------------------------
// ir_pulse_interval_decoder - NEC style IR pulse interval decoder
// Turns timed edge events of an IR receiver into 32-bit key codes.
// ----------------------------------------------------------------------------
// Usage:
//   edge_in carries one word per line edge: edge_kind (falling, rising, or
//   both, which is dropped) and the tick count since the previous edge.
//   code_out carries a 32-bit code whenever the bit count after an edge hits
//   frame_len_a or frame_len_b; most edges give no code. The user must write
//   registers (wr_en/wr_index/wr_data) only while idle; nothing enforces it.
// Timing:
//   One edge word is taken every cycle while edge_in.ready is high. A code
//   passes through the input register and then the output queue before it
//   appears on code_out. The rate is set by the single decode stage.
// Reset:
//   arst_n clears the header flag, shift register and bit count and loads
//   the default thresholds and frame lengths.
// Stall:
//   A two-word output queue holds codes while code_out is stalled; edge_in
//   drops ready only when the queue could otherwise overflow.
// ----------------------------------------------------------------------------
module ir_pulse_interval_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [irpd_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [irpd_pkg::CFG_DATA_W-1:0]  wr_data,
	irpd_edge_if.sink                        edge_in,
	irpd_code_if.source                      code_out
);
	import irpd_pkg::*;

	cfg_t        cfg;
	result_t     res;
	queue_stat_t stat;
	logic [2:0]  level;
	logic        in_take;

	irpd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// hold off new words when the queue could not take their code
	assign level = {1'b0, stat.count} + 3'(stat.push) - 3'(stat.pop);
	assign edge_in.ready = (level < 3'd2);
	assign in_take = edge_in.valid && edge_in.ready;

	irpd_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_take     (in_take),
		.in_kind     (edge_in.edge_kind),
		.in_interval (edge_in.interval),
		.res         (res)
	);

	irpd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.code_out (code_out),
		.stat     (stat)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count != 2'd3)
		else $error("output queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (stat.count != 2'd2 || stat.pop))
		else $error("code pushed into a full queue");

	a_take_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (stat.count != 2'd2 || stat.pop || !res.valid))
		else $error("edge accepted without room for its code");

endmodule

/* sv/irpd_cfg.sv */
// ----------------------------------------------------------------------------
// irpd_cfg - configuration registers
// Holds the thresholds and frame lengths; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
module irpd_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [irpd_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [irpd_pkg::CFG_DATA_W-1:0]  wr_data,
	output irpd_pkg::cfg_t                   cfg
);
	import irpd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_threshold <= RST_BIT_THRESHOLD;
			cfg_q.header_min    <= RST_HEADER_MIN;
			cfg_q.header_max    <= RST_HEADER_MAX;
			cfg_q.frame_len_a   <= RST_FRAME_LEN_A;
			cfg_q.frame_len_b   <= RST_FRAME_LEN_B;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BIT_THRESHOLD: cfg_q.bit_threshold <= wr_data[INTERVAL_W-1:0];
				REG_HEADER_MIN:    cfg_q.header_min    <= wr_data[INTERVAL_W-1:0];
				REG_HEADER_MAX:    cfg_q.header_max    <= wr_data[INTERVAL_W-1:0];
				REG_FRAME_LEN_A:   cfg_q.frame_len_a   <= wr_data[COUNT_W-1:0];
				REG_FRAME_LEN_B:   cfg_q.frame_len_b   <= wr_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/irpd_step.sv */
// ----------------------------------------------------------------------------
// irpd_step - edge decode stage
// Registers one edge word, then updates the header flag, shift register and
// bit count and flags a finished code in the same cycle.
// ----------------------------------------------------------------------------
module irpd_step (
	input  logic                              clk,
	input  logic                              arst_n,
	input  irpd_pkg::cfg_t                    cfg,
	input  logic                              in_take,
	input  logic [irpd_pkg::KIND_W-1:0]       in_kind,
	input  logic [irpd_pkg::INTERVAL_W-1:0]   in_interval,
	output irpd_pkg::result_t                 res
);
	import irpd_pkg::*;

	logic                  valid_s1;
	logic [KIND_W-1:0]     kind_s1;
	logic [INTERVAL_W-1:0] interval_s1;

	logic               started_q;
	logic [CODE_W-1:0]  shift_q;
	logic [COUNT_W-1:0] count_q;

	logic               live;
	logic               header;
	logic               started_d;
	logic [CODE_W-1:0]  shift_d;
	logic [COUNT_W-1:0] count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1     <= in_kind;
			interval_s1 <= in_interval;
		end
	end

	always_comb begin
		live      = valid_s1 && (kind_s1 == EDGE_FALL || kind_s1 == EDGE_RISE);
		header    = (kind_s1 == EDGE_RISE) && (interval_s1 > cfg.header_min)
			&& (interval_s1 < cfg.header_max);
		started_d = started_q;
		shift_d   = shift_q;
		count_d   = count_q;
		if (started_q) begin
			shift_d = {shift_q[CODE_W-2:0], interval_s1 > cfg.bit_threshold};
			if (count_q != COUNT_MAX)
				count_d = count_q + COUNT_W'(1);
		end
		// a header restarts the frame after the shift
		if (header) begin
			shift_d   = '0;
			count_d   = '0;
			started_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			shift_q   <= '0;
			count_q   <= '0;
		end else if (live) begin
			started_q <= started_d;
			shift_q   <= shift_d;
			count_q   <= count_d;
		end
	end

	assign res.valid = live && (count_d == cfg.frame_len_a || count_d == cfg.frame_len_b);
	assign res.code  = shift_d;

endmodule

/* sv/irpd_outq.sv */
// ----------------------------------------------------------------------------
// irpd_outq - two-word output queue
// Parts the decode stage from the receiver so edges keep flowing while a
// code waits; reports its fill level for input flow control.
// ----------------------------------------------------------------------------
module irpd_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  irpd_pkg::result_t    res,
	irpd_code_if.source          code_out,
	output irpd_pkg::queue_stat_t stat
);
	import irpd_pkg::*;

	logic [1:0]        count_q;
	logic [CODE_W-1:0] head_q;
	logic [CODE_W-1:0] tail_q;
	logic              push;
	logic              pop;

	assign push = res.valid;
	assign pop  = code_out.valid && code_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0)
					head_q <= res.code;
				else
					tail_q <= res.code;
			end
			2'b01: head_q <= tail_q;
			2'b11: begin
				if (count_q == 2'd1) begin
					head_q <= res.code;
				end else begin
					head_q <= tail_q;
					tail_q <= res.code;
				end
			end
			default: ;
		endcase
	end

	assign code_out.valid = (count_q != 2'd0);
	assign code_out.code  = head_q;

	assign stat.count = count_q;
	assign stat.push  = push;
	assign stat.pop   = pop;

endmodule

/* tb/sv/ir_pulse_interval_decoder_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_interval_decoder_checker - code predictor and scoreboard
// Watches the register port and both channels of the decoder. Each accepted
// edge word runs through a local decoder model, and any code it yields is
// queued. Each accepted code word is compared with the oldest queued code.
// ----------------------------------------------------------------------------
module ir_pulse_interval_decoder_checker
	import irpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	irpd_edge_if                  edge_mon,
	irpd_code_if                  code_mon,
	output int                    pending_words,
	output int                    mismatches
);

	cfg_t               regs;
	logic               hdr_seen;
	logic [CODE_W-1:0]  shreg;
	logic [COUNT_W-1:0] nbits;
	logic [CODE_W-1:0]  codes_due[$];
	logic [CODE_W-1:0]  want;
	int                 fail_cnt;

	// shift first, then let a header clear, then test the bit count
	task automatic decode_edge(input logic [KIND_W-1:0] kind,
			input logic [INTERVAL_W-1:0] ticks);
		if (kind == EDGE_FALL || kind == EDGE_RISE) begin
			if (hdr_seen) begin
				shreg = {shreg[CODE_W-2:0], ticks > regs.bit_threshold};
				if (nbits != COUNT_MAX)
					nbits++;
			end
			if (kind == EDGE_RISE && ticks > regs.header_min && ticks < regs.header_max) begin
				shreg    = '0;
				nbits    = '0;
				hdr_seen = 1'b1;
			end
			if (nbits == regs.frame_len_a || nbits == regs.frame_len_b)
				codes_due.push_back(shreg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.bit_threshold = RST_BIT_THRESHOLD;
			regs.header_min    = RST_HEADER_MIN;
			regs.header_max    = RST_HEADER_MAX;
			regs.frame_len_a   = RST_FRAME_LEN_A;
			regs.frame_len_b   = RST_FRAME_LEN_B;
			hdr_seen           = 1'b0;
			shreg              = '0;
			nbits              = '0;
			fail_cnt           = 0;
			codes_due.delete();
			pending_words <= 0;
			mismatches    <= 0;
		end else begin
			// compare before predicting: a code never leaves in its own edge's cycle
			if (code_mon.valid && code_mon.ready) begin
				if (codes_due.size() == 0) begin
					if (fail_cnt < 10)
						$display("%0t: code %08h with nothing expected", $realtime,
							code_mon.code);
					fail_cnt++;
				end else begin
					want = codes_due.pop_front();
					if (code_mon.code !== want) begin
						if (fail_cnt < 10)
							$display("%0t: code mismatch, expected %08h, got %08h",
								$realtime, want, code_mon.code);
						fail_cnt++;
					end
				end
			end
			if (edge_mon.valid && edge_mon.ready)
				decode_edge(edge_mon.edge_kind, edge_mon.interval);
			if (wr_en) begin
				case (wr_index)
					REG_BIT_THRESHOLD: regs.bit_threshold = wr_data;
					REG_HEADER_MIN:    regs.header_min    = wr_data;
					REG_HEADER_MAX:    regs.header_max    = wr_data;
					REG_FRAME_LEN_A:   regs.frame_len_a   = wr_data[COUNT_W-1:0];
					REG_FRAME_LEN_B:   regs.frame_len_b   = wr_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			pending_words <= codes_due.size();
			mismatches    <= fail_cnt;
		end
	end

endmodule

/* tb/sv/ir_pulse_interval_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_interval_decoder_tb - stimulus and verdict for the IR decoder
// Sends directed edge words around the header bounds and bit threshold, then
// segments of random frames (header plus a run of bit edges) mixed with
// noise, under several register settings and idle patterns, including a
// long output stall. The checker alongside does all prediction.
// ----------------------------------------------------------------------------
module ir_pulse_interval_decoder_tb;
	import irpd_pkg::*;

	localparam logic [KIND_W-1:0] EDGE_BOTH  = 2'd2;
	localparam logic [KIND_W-1:0] EDGE_UNDEF = 2'd3;
	// longest correct quiet spell is the forced output stall below
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int SEGMENTS    = 8;
	localparam int SEG_WORDS   = 230;
	localparam int BIT_SPREAD  = 20000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  hold_go;
	int                    pending_words;
	int                    mismatches;
	cfg_t                  knobs;
	int                    gap_pct;
	int                    stall_pct;
	int                    sent;
	int                    quiet;

	irpd_edge_if edge_if();
	irpd_code_if code_if();

	ir_pulse_interval_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.edge_in  (edge_if),
		.code_out (code_if)
	);

	ir_pulse_interval_decoder_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.edge_mon      (edge_if),
		.code_mon      (code_if),
		.pending_words (pending_words),
		.mismatches    (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus one long hold while the sender keeps going
	always @(posedge clk) begin
		int  hold_left;
		bit  hold_done;
		if (hold_go && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			code_if.ready <= 1'b0;
		end else begin
			code_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((edge_if.valid && edge_if.ready) || (code_if.valid && code_if.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_edge(input logic [KIND_W-1:0] kind, input logic [INTERVAL_W-1:0] ticks);
		while ($urandom_range(99) < gap_pct) begin
			edge_if.valid <= 1'b0;
			@(posedge clk);
		end
		edge_if.valid     <= 1'b1;
		edge_if.edge_kind <= kind;
		edge_if.interval  <= ticks;
		do @(posedge clk); while (!edge_if.ready);
		if (kind == EDGE_FALL || kind == EDGE_RISE)
			sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		knobs = c;
		write_reg(REG_BIT_THRESHOLD, c.bit_threshold);
		write_reg(REG_HEADER_MIN, c.header_min);
		write_reg(REG_HEADER_MAX, c.header_max);
		write_reg(REG_FRAME_LEN_A, CFG_DATA_W'(c.frame_len_a));
		write_reg(REG_FRAME_LEN_B, CFG_DATA_W'(c.frame_len_b));
		wr_en <= 1'b0;
	endtask

	// drop valid, wait out every due code, then let the pipeline settle
	task automatic drain(input int settle);
		edge_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [INTERVAL_W-1:0] bit_ticks(input logic one);
		logic [INTERVAL_W:0] wide;
		if (knobs.bit_threshold == '1)
			one = 1'b0;
		case ($urandom_range(3))
			0: return one ? 32'hFFFF_FFFF : 32'd0;
			1: return one ? knobs.bit_threshold + 32'd1 : knobs.bit_threshold;
			default: begin
				if (one) begin
					wide = {1'b0, knobs.bit_threshold} + 33'd1 + $urandom_range(BIT_SPREAD);
					return wide[INTERVAL_W] ? 32'hFFFF_FFFF : wide[INTERVAL_W-1:0];
				end
				if (knobs.bit_threshold > BIT_SPREAD)
					return knobs.bit_threshold - $urandom_range(BIT_SPREAD);
				return $urandom_range(knobs.bit_threshold);
			end
		endcase
	endfunction

	function automatic logic [INTERVAL_W-1:0] header_ticks();
		if ({1'b0, knobs.header_max} > {1'b0, knobs.header_min} + 33'd1)
			return $urandom_range(knobs.header_max - 32'd1, knobs.header_min + 32'd1);
		return $urandom;
	endfunction

	// header, then a run of bit edges sized around a frame length or at random
	task automatic send_frame();
		int span;
		case ($urandom_range(3))
			0: span = int'(knobs.frame_len_a);
			1: span = int'(knobs.frame_len_b);
			2: span = $urandom_range(int'(COUNT_MAX) + 8);
			default: span = $urandom_range(8);
		endcase
		span += $urandom_range(2);
		send_edge(EDGE_RISE, header_ticks());
		repeat (span) begin
			if ($urandom_range(19) == 0)
				send_edge($urandom_range(1) ? EDGE_BOTH : EDGE_UNDEF, $urandom);
			send_edge($urandom_range(1) ? EDGE_RISE : EDGE_FALL,
				bit_ticks(1'($urandom_range(1))));
		end
	endtask

	task automatic send_noise();
		logic [INTERVAL_W-1:0] ticks;
		repeat ($urandom_range(6, 1)) begin
			case ($urandom_range(3))
				0: ticks = knobs.header_min;
				1: ticks = knobs.header_max;
				2: ticks = header_ticks();
				default: ticks = $urandom;
			endcase
			send_edge(KIND_W'($urandom_range(3)), ticks);
		end
	endtask

	initial begin
		cfg_t c;
		int   target;
		arst_n            = 1'b0;
		wr_en             = 1'b0;
		wr_index          = '0;
		wr_data           = '0;
		hold_go           = 1'b0;
		edge_if.valid     = 1'b0;
		edge_if.edge_kind = EDGE_FALL;
		edge_if.interval  = '0;
		code_if.ready     = 1'b0;
		gap_pct           = 0;
		stall_pct         = 0;
		sent              = 0;
		quiet             = 0;
		knobs.bit_threshold = RST_BIT_THRESHOLD;
		knobs.header_min    = RST_HEADER_MIN;
		knobs.header_max    = RST_HEADER_MAX;
		knobs.frame_len_a   = RST_FRAME_LEN_A;
		knobs.frame_len_b   = RST_FRAME_LEN_B;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored kinds, edges before any header, header bounds, bit threshold
		send_edge(EDGE_BOTH, 32'd0);
		send_edge(EDGE_UNDEF, 32'hFFFF_FFFF);
		send_edge(EDGE_FALL, 32'hFFFF_FFFF);
		send_edge(EDGE_RISE, RST_HEADER_MIN);
		send_edge(EDGE_RISE, RST_HEADER_MAX);
		send_edge(EDGE_RISE, RST_HEADER_MIN + 32'd1);
		send_edge(EDGE_FALL, RST_BIT_THRESHOLD);
		send_edge(EDGE_FALL, RST_BIT_THRESHOLD + 32'd1);
		send_edge(EDGE_RISE, 32'hFFFF_FFFF);
		send_edge(EDGE_FALL, 32'd0);
		send_edge(EDGE_RISE, RST_HEADER_MAX - 32'd1);
		send_edge(EDGE_BOTH, 32'hFFFF_FFFF);

		// short frames: zero length emits on the header itself
		drain(4);
		c = knobs;
		c.frame_len_a = 6'd3;
		c.frame_len_b = '0;
		program_regs(c);
		send_edge(EDGE_RISE, 32'd100000);
		send_edge(EDGE_FALL, 32'h8000_0000);
		send_edge(EDGE_FALL, 32'd1);
		send_edge(EDGE_RISE, 32'd20000);
		send_edge(EDGE_UNDEF, 32'd0);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain(4);
			c.bit_threshold = RST_BIT_THRESHOLD;
			c.header_min    = RST_HEADER_MIN;
			c.header_max    = RST_HEADER_MAX;
			c.frame_len_a   = RST_FRAME_LEN_A;
			c.frame_len_b   = RST_FRAME_LEN_B;
			case (seg)
				0: ;
				1: begin
					c.bit_threshold = '0;
					c.header_min    = '0;
					c.header_max    = '1;
					c.frame_len_a   = '0;
					c.frame_len_b   = COUNT_MAX;
				end
				2: begin
					// long frames drive the bit count into saturation
					c.bit_threshold = '1;
					c.header_min    = 32'd1000;
					c.header_max    = 32'd2000;
					c.frame_len_a   = COUNT_MAX;
					c.frame_len_b   = 6'd32;
				end
				4: begin
					// empty header window: no frame can restart
					c.bit_threshold = $urandom;
					c.header_min    = '1;
					c.header_max    = '0;
					c.frame_len_a   = '0;
					c.frame_len_b   = COUNT_W'($urandom_range(int'(COUNT_MAX)));
				end
				default: begin
					c.bit_threshold = $urandom_range(100000);
					c.header_min    = c.bit_threshold + $urandom_range(100000);
					c.header_max    = c.header_min + 32'd2 + $urandom_range(1000000);
					c.frame_len_a   = COUNT_W'($urandom_range(40, 1));
					c.frame_len_b   = COUNT_W'($urandom_range(int'(COUNT_MAX)));
				end
			endcase
			if (seg == 1) begin
				for (int i = int'(REG_FRAME_LEN_B) + 1; i < 2 ** CFG_IDX_W; i++)
					write_reg(CFG_IDX_W'(i), $urandom);
			end
			program_regs(c);
			case (seg % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 47; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 47; end
				default: begin gap_pct = 32; stall_pct = 32; end
			endcase
			if (seg == 1)
				hold_go <= 1'b1;
			target = sent + SEG_WORDS;
			while (sent < target) begin
				if ($urandom_range(9) < 8)
					send_frame();
				else
					send_noise();
			end
		end

		drain(8);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
